// File: hdl/bitmap_pixel_format_converter_assert.svh
// ----------------------------------------------------------------------------
// Bitmap pixel format converter assertion macros
// Shared property shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define BITMAP_PIXEL_FORMAT_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define BPFC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpfc assertion failed");

// Next-cycle implication.
`define BPFC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpfc assertion failed");

`endif

// File: hdl/bpfc_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter package
// Register indexes, format codes, configuration types and shared functions.
// ----------------------------------------------------------------------------
package bpfc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_OUTPUT_DEPTH  = 3'd1,
    REG_MASK_RED      = 3'd2,
    REG_MASK_GREEN    = 3'd3,
    REG_MASK_BLUE     = 3'd4,
    REG_CLEAR_BLACK   = 3'd5,
    REG_PINK_KEY      = 3'd6,
    REG_FORCE_STP     = 3'd7
  } cfg_reg_e;

  // Source pixel kinds; codes 6 and 7 behave as 32-bit bitfields.
  localparam logic [2:0] SRC_1BIT  = 3'd0;
  localparam logic [2:0] SRC_4BIT  = 3'd1;
  localparam logic [2:0] SRC_8BIT  = 3'd2;
  localparam logic [2:0] SRC_16BIT = 3'd3;
  localparam logic [2:0] SRC_24BIT = 3'd4;
  localparam logic [2:0] SRC_32BIT = 3'd5;

  // Output modes.
  typedef enum logic [1:0] {
    DEPTH_IDX4  = 2'd0,
    DEPTH_IDX8  = 2'd1,
    DEPTH_RGB15 = 2'd2,
    DEPTH_RGB24 = 2'd3
  } out_depth_e;

  localparam logic [15:0] STP_BIT   = 16'h8000;
  localparam logic [4:0]  CH5_MAX   = 5'h1f;
  localparam logic [14:0] PINK_15   = {CH5_MAX, 5'h00, CH5_MAX};

  // One color channel: its mask plus the alignment derived from it.
  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  shift;   // position of lowest set bit
    logic [2:0]  lsh;     // left shift that scales a narrow field to 8 bits
  } chan_cfg_t;

  typedef struct packed {
    logic [2:0] source_format;
    out_depth_e output_depth;
    chan_cfg_t  red;
    chan_cfg_t  green;
    chan_cfg_t  blue;
    logic       clear_black;
    logic       pink_key;
    logic       force_stp;
  } cfg_t;

  // Derive the channel alignment from a mask at the time it is written.
  function automatic chan_cfg_t chan_setup(logic [31:0] mask);
    chan_cfg_t  c;
    logic [5:0] bits;
    c.mask  = mask;
    c.shift = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) begin
        c.shift = 5'(i);
      end
    end
    bits = 6'($countones(mask));
    if (bits != 6'd0 && bits <= 6'd8) begin
      c.lsh = 3'(6'd8 - bits);
    end else begin
      c.lsh = 3'd0;
    end
    return c;
  endfunction

  // Palette index carried by a pixel word.
  function automatic logic [7:0] pixel_index(logic [2:0] fmt, logic [31:0] v);
    logic [7:0] idx;
    case (fmt)
      SRC_1BIT: idx = {7'd0, v[0]};
      SRC_4BIT: idx = {4'd0, v[3:0]};
      default:  idx = v[7:0];
    endcase
    return idx;
  endfunction

endpackage

// File: hdl/bpfc_if.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter channel interfaces
// Valid/ready channels for input items and for output words.
// ----------------------------------------------------------------------------
interface bpfc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] pixel_value;
  logic [7:0]  palette_slot;
  logic [23:0] palette_color;
  logic        row_end;

  modport source (
    output valid, operation, pixel_value, palette_slot, palette_color, row_end,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_value, palette_slot, palette_color, row_end,
    output ready
  );
endinterface

interface bpfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic        last_of_run;

  modport source (output valid, out_word, last_of_run, input ready);
  modport sink (input valid, out_word, last_of_run, output ready);
endinterface

// File: hdl/bpfc_palette.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter palette memory
// Single-port-write, registered-read palette store with range checks.
// ----------------------------------------------------------------------------
module bpfc_palette #(
  parameter int unsigned Entries = 256
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [7:0]  waddr_i,
  input  logic [23:0] wdata_i,
  input  logic        re_i,
  input  logic [7:0]  raddr_i,
  output logic [23:0] rdata_o
);

  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [23:0] mem [Entries];
  logic [23:0] rdata_q;
  logic        oor_q;
  logic        w_in_range;
  logic        r_in_range;

  // Slots at or beyond the depth are ignored on write and read as black.
  assign w_in_range = ({1'b0, waddr_i} < 9'(Entries));
  assign r_in_range = ({1'b0, raddr_i} < 9'(Entries));

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i && w_in_range) begin
      mem[waddr_i[AddrW-1:0]] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i[AddrW-1:0]];
      oor_q   <= !r_in_range;
    end
  end

  assign rdata_o = oor_q ? 24'd0 : rdata_q;

endmodule

// File: hdl/bpfc_color.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter color unit
// Builds the 24-bit color of a pixel and its 15-bit word with the
// transparency rules.
// ----------------------------------------------------------------------------
module bpfc_color (
  input  bpfc_pkg::cfg_t cfg_i,
  input  logic [31:0]    pixel_i,
  input  logic [23:0]    pal_color_i,
  output logic [23:0]    color_o,
  output logic [15:0]    rgb15_o
);
  import bpfc_pkg::*;

  // Mask a channel, align it to bit 0 and scale narrow fields to 8 bits.
  function automatic logic [7:0] take_channel(logic [31:0] w, chan_cfg_t c);
    logic [31:0] v;
    v = (w & c.mask) >> c.shift;
    v = v << c.lsh;
    return v[7:0];
  endfunction

  logic [31:0] word;
  logic [14:0] c15;

  // Pick the color source by pixel kind.
  always_comb begin
    word = (cfg_i.source_format == SRC_16BIT) ? {16'd0, pixel_i[15:0]} : pixel_i;
    if (cfg_i.source_format inside {SRC_1BIT, SRC_4BIT, SRC_8BIT}) begin
      color_o = pal_color_i;
    end else if (cfg_i.source_format == SRC_24BIT) begin
      color_o = pixel_i[23:0];
    end else begin
      color_o = {take_channel(word, cfg_i.red), take_channel(word, cfg_i.green),
                 take_channel(word, cfg_i.blue)};
    end
  end

  // Reduce to 5 bits per channel: red low, blue high.
  assign c15 = {color_o[7:3], color_o[15:11], color_o[23:19]};

  // Magenta and black rules, then the semi-transparency bit.
  always_comb begin
    if (cfg_i.pink_key && c15 == PINK_15) begin
      rgb15_o = 16'd0;
    end else if (c15 == 15'd0) begin
      rgb15_o = cfg_i.clear_black ? 16'd0 : STP_BIT;
    end else if (cfg_i.force_stp) begin
      rgb15_o = {1'b0, c15} | STP_BIT;
    end else begin
      rgb15_o = {1'b0, c15};
    end
  end

endmodule

// File: hdl/bpfc_pack.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter packer
// Packs indices or colors into 16-bit words and serves each item's words
// from a small output buffer, one word per beat.
// ----------------------------------------------------------------------------
module bpfc_pack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpfc_pkg::cfg_t       cfg_i,
  input  logic                 clear_i,
  input  logic                 item_valid_i,
  input  logic                 row_end_i,
  input  logic [31:0]          pixel_i,
  input  logic [23:0]          color_i,
  input  logic [15:0]          rgb15_i,
  output logic                 item_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          out_word_o,
  output logic                 out_last_o
);
  import bpfc_pkg::*;

  logic [23:0] held_q, held_d;
  logic [15:0] pbuf_q, pbuf_d;
  logic [1:0]  pcnt_q, pcnt_d;
  logic [15:0] w0_q, w1_q, w2_q;
  logic [15:0] g0, g1, g2;
  logic [1:0]  cnt_q;
  logic [1:0]  nwords;
  logic [7:0]  idx;
  logic [15:0] merged;
  logic        full;
  logic [23:0] c1, c2;
  logic        step;
  logic        take;

  // A new group loads once the buffer is empty or is handing out its last word.
  assign item_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign step         = item_valid_i && item_ready_o;
  assign out_valid_o  = (cnt_q != 2'd0);
  assign take         = out_valid_o && out_ready_i;
  assign out_word_o   = w0_q;
  assign out_last_o   = (cnt_q == 2'd1);
  assign idx          = pixel_index(cfg_i.source_format, pixel_i);

  // Group assembly for the current pixel.
  always_comb begin
    held_d = held_q;
    pbuf_d = pbuf_q;
    pcnt_d = pcnt_q;
    nwords = 2'd0;
    g0     = 16'd0;
    g1     = 16'd0;
    g2     = 16'd0;
    merged = 16'd0;
    full   = 1'b0;
    c1     = 24'd0;
    c2     = 24'd0;
    case (cfg_i.output_depth)
      DEPTH_IDX4, DEPTH_IDX8: begin
        if (cfg_i.output_depth == DEPTH_IDX4) begin
          merged = pbuf_q | (16'(idx[3:0]) << {pcnt_q, 2'b00});
          full   = (pcnt_q == 2'd3);
        end else begin
          merged = pbuf_q | (16'(idx) << {pcnt_q[0], 3'b000});
          full   = pcnt_q[0];
        end
        if (full || row_end_i) begin
          g0     = merged;
          nwords = 2'd1;
          pbuf_d = 16'd0;
          pcnt_d = 2'd0;
        end else begin
          pbuf_d = merged;
          pcnt_d = (cfg_i.output_depth == DEPTH_IDX4) ? pcnt_q + 2'd1
                                                       : {1'b0, ~pcnt_q[0]};
        end
      end
      DEPTH_RGB15: begin
        g0     = rgb15_i;
        nwords = 2'd1;
      end
      default: begin
        // Two pixels make three words; a lone pixel at row end pairs with black.
        if (pcnt_q == 2'd0) begin
          c1 = color_i;
          c2 = 24'd0;
        end else begin
          c1 = held_q;
          c2 = color_i;
        end
        if (pcnt_q == 2'd0 && !row_end_i) begin
          held_d = color_i;
          pcnt_d = 2'd1;
        end else begin
          held_d = 24'd0;
          pcnt_d = 2'd0;
          nwords = 2'd3;
          g0     = {c1[15:8], c1[23:16]};
          g1     = {c2[23:16], c1[7:0]};
          g2     = {c2[7:0], c2[15:8]};
        end
      end
    endcase
  end

  // Packing state; a change of output mode drops any partial group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 24'd0;
      pbuf_q <= 16'd0;
      pcnt_q <= 2'd0;
      cnt_q  <= 2'd0;
    end else begin
      if (clear_i) begin
        held_q <= 24'd0;
        pbuf_q <= 16'd0;
        pcnt_q <= 2'd0;
      end else if (step) begin
        held_q <= held_d;
        pbuf_q <= pbuf_d;
        pcnt_q <= pcnt_d;
      end
      if (step && nwords != 2'd0) begin
        cnt_q <= nwords;
      end else if (take) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Output words shift toward the port as they are taken.
  always_ff @(posedge clk_i) begin
    if (step && nwords != 2'd0) begin
      w0_q <= g0;
      w1_q <= g1;
      w2_q <= g2;
    end else if (take) begin
      w0_q <= w1_q;
      w1_q <= w2_q;
    end
  end

endmodule

// File: hdl/bitmap_pixel_format_converter.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter
// Converts indexed or bitfield pixels into 16-bit words of packed indices,
// 15-bit color or 24-bit color.
// ----------------------------------------------------------------------------
// A new item can be accepted every cycle while the pixel stage is empty
// or passes its pixel on. A pixel waits in the palette read (the
// registered memory port) and is converted and packed once the output
// buffer can take its words; palette writes finish at acceptance. The
// output port moves one word per beat, so 4-bit and 8-bit index modes and
// 15-bit color run at one pixel per cycle while the port is ready. In
// 24-bit color a pair of pixels makes three words: the first pixel of a
// pair is packed together with the last word of the previous group, and the
// port idles while the second is packed. The palette needs no initialization;
// entries must be written before they are looked up. Configuration writes
// must be made only while the block is idle; the block does not enforce it.
module bitmap_pixel_format_converter #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpfc_in_if.sink     in_ch,
  bpfc_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import bpfc_pkg::*;

  cfg_t        cfg_q;
  logic        s1_valid_q;
  logic [31:0] s1_pixel_q;
  logic        s1_row_end_q;
  logic        accept;
  logic        item_ready;
  logic [23:0] pal_color;
  logic [23:0] color;
  logic [15:0] rgb15;
  logic        depth_clear;

  assign in_ch.ready = !s1_valid_q || item_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign depth_clear = cfg_we_i && (cfg_index_i == REG_OUTPUT_DEPTH);

  // Configuration registers; mask alignment is derived as the mask is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_format <= SRC_16BIT;
      cfg_q.output_depth  <= DEPTH_RGB15;
      cfg_q.red           <= chan_setup(32'h0000_7c00);
      cfg_q.green         <= chan_setup(32'h0000_03e0);
      cfg_q.blue          <= chan_setup(32'h0000_001f);
      cfg_q.clear_black   <= 1'b0;
      cfg_q.pink_key      <= 1'b0;
      cfg_q.force_stp     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SOURCE_FORMAT: cfg_q.source_format <= cfg_wdata_i[2:0];
        REG_OUTPUT_DEPTH:  cfg_q.output_depth  <= out_depth_e'(cfg_wdata_i[1:0]);
        REG_MASK_RED:      cfg_q.red           <= chan_setup(cfg_wdata_i);
        REG_MASK_GREEN:    cfg_q.green         <= chan_setup(cfg_wdata_i);
        REG_MASK_BLUE:     cfg_q.blue          <= chan_setup(cfg_wdata_i);
        REG_CLEAR_BLACK:   cfg_q.clear_black   <= cfg_wdata_i[0];
        REG_PINK_KEY:      cfg_q.pink_key      <= cfg_wdata_i[0];
        REG_FORCE_STP:     cfg_q.force_stp     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Pixel stage alongside the palette read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && !in_ch.operation) begin
      s1_valid_q <= 1'b1;
    end else if (s1_valid_q && item_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_ch.operation) begin
      s1_pixel_q   <= in_ch.pixel_value;
      s1_row_end_q <= in_ch.row_end;
    end
  end

  // Palette store: written by palette items, read for every pixel.
  bpfc_palette #(
    .Entries (PALETTE_ENTRIES)
  ) u_bpfc_palette (
    .clk_i   (clk_i),
    .we_i    (accept && in_ch.operation),
    .waddr_i (in_ch.palette_slot),
    .wdata_i (in_ch.palette_color),
    .re_i    (accept && !in_ch.operation),
    .raddr_i (pixel_index(cfg_q.source_format, in_ch.pixel_value)),
    .rdata_o (pal_color)
  );

  bpfc_color u_bpfc_color (
    .cfg_i       (cfg_q),
    .pixel_i     (s1_pixel_q),
    .pal_color_i (pal_color),
    .color_o     (color),
    .rgb15_o     (rgb15)
  );

  bpfc_pack u_bpfc_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clear_i      (depth_clear),
    .item_valid_i (s1_valid_q),
    .row_end_i    (s1_row_end_q),
    .pixel_i      (s1_pixel_q),
    .color_i      (color),
    .rgb15_i      (rgb15),
    .item_ready_o (item_ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_word_o   (out_ch.out_word),
    .out_last_o   (out_ch.last_of_run)
  );

endmodule

// File: hdl/bpfc_checker.sv
// ----------------------------------------------------------------------------
// Bitmap pixel format converter port checker
// Watches the top-level ports for output ordering and handshake behavior.
// ----------------------------------------------------------------------------
`include "bitmap_pixel_format_converter_assert.svh"

module bpfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_word_i,
  input logic        out_last_i
);

  // A waiting word stays offered and unchanged.
  `BPFC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `BPFC_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i,
                   $stable(out_word_i) && $stable(out_last_i))

  // Words of one item follow without a gap.
  `BPFC_ASSERT_NXT(a_run_continues, out_valid_i && out_ready_i && !out_last_i,
                   out_valid_i)

  // Output starts only after an item was taken.
  `BPFC_ASSERT_IMP(a_start_after_accept, $rose(out_valid_i),
                   $past(in_valid_i && in_ready_i, 2))

endmodule

bind bitmap_pixel_format_converter bpfc_checker u_bpfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_word_i  (out_ch.out_word),
  .out_last_i  (out_ch.last_of_run)
);
